@@ design/fcea_pkg.sv @@
// ----------------------------------------------------------------------------
// fcea_pkg
// Shared types and constants for the flow counter extension and aging block.
// ----------------------------------------------------------------------------
package fcea_pkg;

    localparam int FLOW_ENTRIES_DEF = 1024;
    localparam int INDEX_W          = 10;
    localparam int DEV_BYTES_W      = 48;
    localparam int DEV_PKTS_W       = 40;
    localparam int TOTAL_W          = 64;
    localparam int TIME_W           = 64;
    localparam int AGE_W            = 32;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 32'd180000000;

    typedef enum logic {
        OP_INSTALL = 1'b0,
        OP_POLL    = 1'b1
    } op_e;

    typedef struct packed {
        op_e                    op;
        logic [INDEX_W-1:0]     flow_index;
        logic                   device_counts_valid;
        logic [DEV_BYTES_W-1:0] device_bytes;
        logic [DEV_PKTS_W-1:0]  device_packets;
        logic [TIME_W-1:0]      now_usec;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]   entry_index;
        logic                 aged;
        logic                 updated;
        logic [DEV_BYTES_W:0] delta_bytes;
        logic [DEV_PKTS_W:0]  delta_packets;
        logic [TOTAL_W-1:0]   total_bytes;
        logic [TOTAL_W-1:0]   total_packets;
    } out_item_t;

    // One flow table entry
    typedef struct packed {
        logic [TOTAL_W-1:0] byte_total;
        logic [TOTAL_W-1:0] packet_total;
        logic [TIME_W-1:0]  last_active_time;
    } entry_t;

    // Write-back request from the update logic
    typedef struct packed {
        logic   wr_en;
        entry_t wr_data;
    } wr_req_t;

endpackage

@@ design/fcea_index.sv @@
// ----------------------------------------------------------------------------
// fcea_index
// Reduces the flow index modulo the table depth: the quotient estimate by
// reciprocal is registered at load, the remainder and its single
// correction follow in the next cycle.
// ----------------------------------------------------------------------------
module fcea_index #(
    parameter int FLOW_ENTRIES = fcea_pkg::FLOW_ENTRIES_DEF,
    parameter int IDX_W        = $clog2(FLOW_ENTRIES)
) (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [fcea_pkg::INDEX_W-1:0] flow_index,
    output logic [IDX_W-1:0]             idx
);
    import fcea_pkg::*;

    localparam int SHIFT = 2 * INDEX_W;
    // Floor reciprocal; N_LO is zero when the table covers every index
    localparam logic [SHIFT-1:0]   RECIP  = SHIFT'((2 ** SHIFT) / FLOW_ENTRIES);
    localparam logic [INDEX_W-1:0] N_LO   = INDEX_W'(FLOW_ENTRIES % (2 ** INDEX_W));
    localparam logic [SHIFT:0]     N_FULL = (SHIFT + 1)'(FLOW_ENTRIES);

    logic [INDEX_W-1:0]         x_reg;
    logic [INDEX_W-1:0]         q_reg;
    logic [INDEX_W+SHIFT-1:0]   q_prod;
    logic [2*INDEX_W-1:0]       qn_prod;
    logic [INDEX_W-1:0]         r_pre;
    logic [INDEX_W-1:0]         r;

    assign q_prod = {{INDEX_W{1'b0}}, flow_index} * {{INDEX_W{1'b0}}, RECIP};

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg <= flow_index;
            q_reg <= q_prod[INDEX_W+SHIFT-1:SHIFT];
        end
    end

    // Estimate is the true quotient or one below it; at most one subtract
    assign qn_prod = {{INDEX_W{1'b0}}, q_reg} * {{INDEX_W{1'b0}}, N_LO};
    assign r_pre   = x_reg - qn_prod[INDEX_W-1:0];

    always_comb begin
        r = r_pre;
        if ({{(SHIFT + 1 - INDEX_W){1'b0}}, r_pre} >= N_FULL) begin
            r = r_pre - N_LO;
        end
    end

    assign idx = IDX_W'(r);

endmodule

@@ design/fcea_store.sv @@
// ----------------------------------------------------------------------------
// fcea_store
// Flow table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fcea_store #(
    parameter int FLOW_ENTRIES = fcea_pkg::FLOW_ENTRIES_DEF,
    parameter int IDX_W        = $clog2(FLOW_ENTRIES)
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output fcea_pkg::entry_t     rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  fcea_pkg::entry_t     wr_data
);
    import fcea_pkg::*;

    entry_t entry_mem [FLOW_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/fcea_update.sv @@
// ----------------------------------------------------------------------------
// fcea_update
// Modify step of the read-modify-write: aging decision, counter extension,
// deltas and the entry to write back.
// ----------------------------------------------------------------------------
module fcea_update (
    input  fcea_pkg::in_item_t              item,
    input  fcea_pkg::entry_t                entry,
    input  logic [fcea_pkg::AGE_W-1:0]      age_limit,
    input  logic [fcea_pkg::INDEX_W-1:0]    entry_index,
    output fcea_pkg::out_item_t             result,
    output fcea_pkg::wr_req_t               wr_req
);
    import fcea_pkg::*;

    localparam int HI_B_W = TOTAL_W - DEV_BYTES_W;
    localparam int HI_P_W = TOTAL_W - DEV_PKTS_W;

    logic [DEV_BYTES_W-1:0] lo_b;
    logic [HI_B_W-1:0]      hi_b;
    logic [DEV_PKTS_W-1:0]  lo_p;
    logic [HI_P_W-1:0]      hi_p;
    logic [DEV_BYTES_W:0]   b_diff;
    logic [DEV_PKTS_W:0]    p_diff;
    logic                   b_wrap;
    logic                   p_wrap;
    logic [TOTAL_W-1:0]     new_b;
    logic [TOTAL_W-1:0]     new_p;
    logic [TIME_W-1:0]      idle;
    logic                   past_limit;
    logic                   is_poll;
    logic                   busy;
    logic                   aged;
    logic                   change;

    assign lo_b = entry.byte_total[DEV_BYTES_W-1:0];
    assign hi_b = entry.byte_total[TOTAL_W-1:DEV_BYTES_W];
    assign lo_p = entry.packet_total[DEV_PKTS_W-1:0];
    assign hi_p = entry.packet_total[TOTAL_W-1:DEV_PKTS_W];

    // Borrow out of the low-part difference marks a device counter wrap
    assign b_diff = {1'b0, item.device_bytes} - {1'b0, lo_b};
    assign p_diff = {1'b0, item.device_packets} - {1'b0, lo_p};
    assign b_wrap = b_diff[DEV_BYTES_W];
    assign p_wrap = p_diff[DEV_PKTS_W];

    assign new_b = {hi_b + HI_B_W'(b_wrap), item.device_bytes};
    assign new_p = {hi_p + HI_P_W'(p_wrap), item.device_packets};

    assign idle       = item.now_usec - entry.last_active_time;
    assign past_limit = (idle[TIME_W-1:AGE_W] != '0) || (idle[AGE_W-1:0] >= age_limit);

    assign is_poll = (item.op == OP_POLL);
    assign busy    = item.device_counts_valid && (lo_b < item.device_bytes);
    assign aged    = is_poll && !busy && past_limit;
    assign change  = is_poll && !aged && item.device_counts_valid
                     && (lo_b != item.device_bytes);

    always_comb begin
        result.entry_index   = entry_index;
        result.aged          = aged;
        result.updated       = change;
        result.delta_bytes   = '0;
        result.delta_packets = '0;
        result.total_bytes   = entry.byte_total;
        result.total_packets = entry.packet_total;
        wr_req.wr_en         = 1'b0;
        wr_req.wr_data       = entry;

        if (!is_poll) begin
            result.total_bytes   = '0;
            result.total_packets = '0;
            wr_req.wr_en         = 1'b1;
            wr_req.wr_data       = '{byte_total: '0, packet_total: '0,
                                     last_active_time: item.now_usec};
        end else if (change) begin
            // Delta stays below one wrap step, so the low bits of the difference hold it
            result.delta_bytes   = {1'b0, b_diff[DEV_BYTES_W-1:0]};
            result.delta_packets = {1'b0, p_diff[DEV_PKTS_W-1:0]};
            result.total_bytes   = new_b;
            result.total_packets = new_p;
            wr_req.wr_en         = 1'b1;
            wr_req.wr_data       = '{byte_total: new_b, packet_total: new_p,
                                     last_active_time: item.now_usec};
        end
    end

endmodule

@@ design/flow_counter_extend_and_age.sv @@
// ----------------------------------------------------------------------------
// flow_counter_extend_and_age
// Per-flow extension of wrapping device counters with idle aging.
// ----------------------------------------------------------------------------
// Input items (s_valid/s_ready/s_item) either install a flow entry or poll it
// with counts read from the device. Each item gives exactly one result on
// m_valid/m_ready/m_item. The age limit is written through cfg_we/cfg_wdata
// by the user only while the block is idle (no check); the next item uses it.
//
// Each item is a read-modify-write of one entry of the flow table memory:
// accept (index quotient registered), read (remainder forms the address,
// entry read), modify (result registered, entry written back). A new item
// is taken in the modify step of the previous one when the output register
// is free, so the single read-modify-write of the table overlaps the next
// accept. The read of the next item lands in the cycle after the previous
// write, so back-to-back items on one entry see fresh data.
//
// A full output register lets one more item be accepted and read; it then
// holds in the modify step until the receiver takes the waiting result.
// Reset clears control state and loads the default age limit; table contents
// are undefined until an install writes them.
// ----------------------------------------------------------------------------
module flow_counter_extend_and_age #(
    parameter int FLOW_ENTRIES = fcea_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fcea_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fcea_pkg::out_item_t         m_item,
    input  logic                        cfg_we,
    input  logic [fcea_pkg::AGE_W-1:0]  cfg_wdata
);
    import fcea_pkg::*;

    localparam int IDX_W = $clog2(FLOW_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_READ   = 3'b010,
        ST_MODIFY = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    in_item_t           item_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_item_reg;
    logic [AGE_W-1:0]   age_limit_reg;

    logic               accept;
    logic               out_free;
    logic               finish;
    logic [IDX_W-1:0]   idx;
    entry_t             rd_entry;
    out_item_t          result;
    wr_req_t            wr_req;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_MODIFY) && out_free);
    assign accept   = s_valid && s_ready;
    assign finish   = (state_reg == ST_MODIFY) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                if (finish) begin
                    state_next = accept ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            age_limit_reg <= AGE_LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                age_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
        if (finish) begin
            m_item_reg <= result;
        end
    end

    fcea_index #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_index (
        .aclk       (aclk),
        .load       (accept),
        .flow_index (s_item.flow_index),
        .idx        (idx)
    );

    fcea_store #(
        .FLOW_ENTRIES (FLOW_ENTRIES),
        .IDX_W        (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (idx),
        .rd_data (rd_entry),
        .wr_en   (finish && wr_req.wr_en),
        .wr_addr (idx),
        .wr_data (wr_req.wr_data)
    );

    fcea_update u_update (
        .item        (item_reg),
        .entry       (rd_entry),
        .age_limit   (age_limit_reg),
        .entry_index (INDEX_W'(idx)),
        .result      (result),
        .wr_req      (wr_req)
    );

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ design/fcea_checker.sv @@
// ----------------------------------------------------------------------------
// fcea_checker
// Port-level checks for the flow counter block, bound to the top level.
// ----------------------------------------------------------------------------
module fcea_checker #(
    parameter int FLOW_ENTRIES = fcea_pkg::FLOW_ENTRIES_DEF
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input fcea_pkg::out_item_t    m_item
);
    import fcea_pkg::*;

    localparam logic [31:0] ENTRIES_CAP = 32'(FLOW_ENTRIES);

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed or dropped while stalled");

    // An accepted item always occupies the read cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted during read cycle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({{(32 - INDEX_W){1'b0}}, m_item.entry_index} < ENTRIES_CAP))
        else $error("entry index beyond table");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_item.aged && m_item.updated))
        else $error("aged flow reported as updated");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.updated |-> (m_item.delta_bytes == '0)
                                       && (m_item.delta_packets == '0))
        else $error("non-zero delta without update");

endmodule

bind flow_counter_extend_and_age fcea_checker #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
) u_fcea_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

@@ dv/flow_counter_extend_and_age_test.sv @@
// ----------------------------------------------------------------------------
// flow_counter_extend_and_age_test
// Self-checking bench for per-flow counter extension and idle aging.
// ----------------------------------------------------------------------------
// A short table of directed items covers installs, wraps of both counters,
// equal byte counts, time running backwards and aging at the exact limit.
// Random phases follow, each under its own age limit. Most items poll a few
// hot flows with rising device counts. The rest are installs, polls without
// counts, stale counts and random counts. Every result is checked against
// a directed row's given result or a local model of the flow table. The
// sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module flow_counter_extend_and_age_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcea_pkg::*;

    localparam int FLOW_ENTRIES = FLOW_ENTRIES_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOT_FLOWS    = 8;
    localparam int PHASE_ITEMS  = 270;
    localparam int DIR_ROWS     = 18;

    localparam out_item_t NO_WANT = '0;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_SPARSE
    } rx_pattern_e;

    typedef struct packed {
        logic      given;
        in_item_t  stim;
        out_item_t want;
    } dir_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_item    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_item;
    logic             cfg_we    = 1'b0;
    logic [AGE_W-1:0] cfg_wdata = '0;

    // Local copy of the flow table and the age limit
    logic [TOTAL_W-1:0] tab_bytes [FLOW_ENTRIES];
    logic [TOTAL_W-1:0] tab_pkts  [FLOW_ENTRIES];
    logic [TIME_W-1:0]  tab_stamp [FLOW_ENTRIES];
    logic [AGE_W-1:0]   age_limit = AGE_LIMIT_RESET;

    out_item_t          awaited_results [$];
    bit                 installed [FLOW_ENTRIES];
    logic [INDEX_W-1:0] installed_list [$];

    logic [INDEX_W-1:0]     hot_flow  [HOT_FLOWS];
    logic [DEV_BYTES_W-1:0] hot_bytes [HOT_FLOWS];
    logic [DEV_PKTS_W-1:0]  hot_pkts  [HOT_FLOWS];

    logic [TIME_W-1:0] clock_usec  = '0;
    int                burst_left  = 0;
    int                mismatches  = 0;
    int                cycle_count = 0;
    rx_pattern_e       ready_mode  = RX_STEADY;
    int                ready_left  = 0;

    dir_row_t directed_rows [DIR_ROWS] = '{
        // installs at both ends of the table and of time
        {1'b1, {OP_INSTALL, 10'd0, 1'b0, 48'd0, 40'd0, 64'd0},
               {10'd0, 1'b0, 1'b0, 49'd0, 41'd0, 64'd0, 64'd0}},
        {1'b1, {OP_INSTALL, 10'd1023, 1'b1, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF},
               {10'd1023, 1'b0, 1'b0, 49'd0, 41'd0, 64'd0, 64'd0}},
        // equal bytes, packets differ: nothing changes
        {1'b1, {OP_POLL, 10'd0, 1'b1, 48'd0, 40'd5, 64'd10},
               {10'd0, 1'b0, 1'b0, 49'd0, 41'd0, 64'd0, 64'd0}},
        {1'b1, {OP_POLL, 10'd0, 1'b1, 48'd100, 40'd3, 64'd20},
               {10'd0, 1'b0, 1'b1, 49'd100, 41'd3, 64'd100, 64'd3}},
        {1'b0, {OP_POLL, 10'd0, 1'b0, 48'hA5A5_A5A5_A5A5, 40'h5A_5A5A_5A5A, 64'd30},
               NO_WANT},
        {1'b0, {OP_POLL, 10'd0, 1'b1, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 64'd40},
               NO_WANT},
        // both counters wrap
        {1'b0, {OP_POLL, 10'd0, 1'b1, 48'd5, 40'd2, 64'd50}, NO_WANT},
        // idle exactly the default limit
        {1'b0, {OP_POLL, 10'd0, 1'b0, 48'd0, 40'd0, 64'd180000050}, NO_WANT},
        {1'b0, {OP_POLL, 10'd0, 1'b1, 48'd5, 40'd9, 64'd180000050}, NO_WANT},
        {1'b0, {OP_POLL, 10'd0, 1'b1, 48'd6, 40'd10, 64'd400000000}, NO_WANT},
        // time runs backwards past zero
        {1'b1, {OP_POLL, 10'd1023, 1'b0, 48'd0, 40'd0, 64'd0},
               {10'd1023, 1'b0, 1'b0, 49'd0, 41'd0, 64'd0, 64'd0}},
        {1'b1, {OP_POLL, 10'd1023, 1'b0, 48'd0, 40'd0, 64'hFFFF_FFFF_FFFF_FFFE},
               {10'd1023, 1'b1, 1'b0, 49'd0, 41'd0, 64'd0, 64'd0}},
        {1'b1, {OP_INSTALL, 10'd512, 1'b0, 48'd0, 40'd0, 64'd1000},
               {10'd512, 1'b0, 1'b0, 49'd0, 41'd0, 64'd0, 64'd0}},
        {1'b0, {OP_POLL, 10'd512, 1'b1, 48'h8000_0000_0000, 40'h80_0000_0000, 64'd1001},
               NO_WANT},
        {1'b0, {OP_POLL, 10'd512, 1'b1, 48'h7FFF_FFFF_FFFF, 40'h7F_FFFF_FFFF, 64'd1002},
               NO_WANT},
        {1'b0, {OP_POLL, 10'd512, 1'b1, 48'h7FFF_FFFF_FFFF, 40'd0, 64'd1003}, NO_WANT},
        {1'b1, {OP_INSTALL, 10'd512, 1'b0, 48'd0, 40'd0, 64'h8000_0000_0000_0000},
               {10'd512, 1'b0, 1'b0, 49'd0, 41'd0, 64'd0, 64'd0}},
        // idle one short of the limit
        {1'b0, {OP_POLL, 10'd512, 1'b0, 48'd0, 40'd0, 64'h8000_0000_0ABA_94FF}, NO_WANT}
    };

    flow_counter_extend_and_age u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one item to the local table and return the result it gives
    function automatic out_item_t advance_flow(input in_item_t it);
        out_item_t          res;
        logic [INDEX_W-1:0] e;
        logic [TOTAL_W-1:0] old_b, old_p, new_b, new_p, diff;
        logic [15:0]        hi_b;
        logic [23:0]        hi_p;
        logic               busy;
        res = '0;
        e = it.flow_index;
        res.entry_index = e;
        if (it.op == OP_INSTALL) begin
            tab_bytes[e] = '0;
            tab_pkts[e]  = '0;
            tab_stamp[e] = it.now_usec;
        end else begin
            old_b = tab_bytes[e];
            old_p = tab_pkts[e];
            busy = it.device_counts_valid && (old_b[47:0] < it.device_bytes);
            if (!busy && (it.now_usec - tab_stamp[e]) >= {32'd0, age_limit}) begin
                res.aged = 1'b1;
            end else if (it.device_counts_valid && old_b[47:0] != it.device_bytes) begin
                // carry one wrap into the high part when the low part went down
                hi_b = old_b[63:48] + 16'(old_b[47:0] > it.device_bytes);
                hi_p = old_p[63:40] + 24'(old_p[39:0] > it.device_packets);
                new_b = {hi_b, it.device_bytes};
                new_p = {hi_p, it.device_packets};
                diff = new_b - old_b;
                res.delta_bytes = diff[48:0];
                diff = new_p - old_p;
                res.delta_packets = diff[40:0];
                tab_bytes[e] = new_b;
                tab_pkts[e]  = new_p;
                tab_stamp[e] = it.now_usec;
                res.updated = 1'b1;
            end
        end
        res.total_bytes   = tab_bytes[e];
        res.total_packets = tab_pkts[e];
        return res;
    endfunction

    function automatic in_item_t random_noise();
        in_item_t    it;
        logic [63:0] r;
        r = {$urandom, $urandom};
        it.op = ($urandom_range(0, 1) == 0) ? OP_INSTALL : OP_POLL;
        it.flow_index = INDEX_W'($urandom_range(0, FLOW_ENTRIES - 1));
        it.device_counts_valid = ($urandom_range(0, 1) == 1);
        it.device_bytes = r[47:0];
        r = {$urandom, $urandom};
        it.device_packets = r[39:0];
        it.now_usec = clock_usec;
        return it;
    endfunction

    function automatic logic [INDEX_W-1:0] pick_installed();
        return installed_list[$urandom_range(0, installed_list.size() - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch in %0s: expected %0h, got %0h", what, want_v, got_v);
        end
    endtask

    task automatic push_item(input in_item_t it, input bit given, input out_item_t want);
        out_item_t calc;
        int        k;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        calc = advance_flow(it);
        awaited_results.push_back(given ? want : calc);
        if (it.op == OP_INSTALL) begin
            if (!installed[it.flow_index]) begin
                installed[it.flow_index] = 1'b1;
                installed_list.push_back(it.flow_index);
            end
            // a fresh entry starts the device counts again
            for (k = 0; k < HOT_FLOWS; k++) begin
                if (hot_flow[k] == it.flow_index) begin
                    hot_bytes[k] = '0;
                    hot_pkts[k]  = '0;
                end
            end
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_age_limit(input logic [AGE_W-1:0] limit);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_we <= 1'b0;
        age_limit = limit;
    endtask

    task automatic run_phase(input logic [AGE_W-1:0] limit, input int unsigned step_max);
        in_item_t    it;
        logic [63:0] r;
        int          n, k, pick;
        set_age_limit(limit);
        for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 49) == 0) begin
                clock_usec = {$urandom, $urandom};
            end else begin
                clock_usec += 64'($urandom_range(0, step_max));
            end
            it = random_noise();
            pick = $urandom_range(0, 99);
            if (n < HOT_FLOWS) begin
                // open the phase by installing its hot flows
                hot_flow[n] = it.flow_index;
                it.op = OP_INSTALL;
            end else if (pick < 6) begin
                it.op = OP_INSTALL;
            end else if (pick < 76) begin
                k = $urandom_range(0, HOT_FLOWS - 1);
                it.op = OP_POLL;
                it.flow_index = hot_flow[k];
                it.device_counts_valid = 1'b0;
                if (pick < 66) begin
                    // advance the device counts: hold, step, jump or run up to the top
                    pick = $urandom_range(0, 99);
                    r = {$urandom, $urandom};
                    if (pick >= 92) begin
                        hot_bytes[k] = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3000));
                    end else if (pick >= 80) begin
                        hot_bytes[k] = r[47:0];
                    end else if (pick >= 10) begin
                        hot_bytes[k] += 48'($urandom_range(1, 5000));
                    end
                    pick = $urandom_range(0, 99);
                    if (pick >= 93) begin
                        hot_pkts[k] = 40'hFF_FFFF_FFFF - 40'($urandom_range(0, 60));
                    end else if (pick >= 85) begin
                        hot_pkts[k] = r[63:24];
                    end else if (pick >= 15) begin
                        hot_pkts[k] += 40'($urandom_range(1, 40));
                    end
                    it.device_counts_valid = 1'b1;
                    it.device_bytes = hot_bytes[k];
                    it.device_packets = hot_pkts[k];
                end
            end else if (pick < 86) begin
                if (it.op == OP_POLL && !installed[it.flow_index]) begin
                    it.flow_index = pick_installed();
                end
            end else begin
                // stale counts: device bytes equal to what the entry holds
                it.op = OP_POLL;
                it.flow_index = pick_installed();
                it.device_counts_valid = 1'b1;
                it.device_bytes = tab_bytes[it.flow_index][47:0];
            end
            push_item(it, 1'b0, NO_WANT);
        end
    endtask

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= rx_pattern_e'($urandom_range(0, 3));
            ready_left <= $urandom_range(16, 160);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            RX_STEADY: begin
                m_ready <= 1'b1;
            end
            RX_COIN: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            RX_EVERY_FOURTH: begin
                m_ready <= (cycle_count[1:0] == 2'd0);
            end
            default: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result, entry", '0, 64'(m_item.entry_index));
            end else begin
                want = awaited_results.pop_front();
                if (m_item.entry_index !== want.entry_index)
                    report_mismatch("entry_index", 64'(want.entry_index),
                                    64'(m_item.entry_index));
                if (m_item.aged !== want.aged)
                    report_mismatch("aged", 64'(want.aged), 64'(m_item.aged));
                if (m_item.updated !== want.updated)
                    report_mismatch("updated", 64'(want.updated), 64'(m_item.updated));
                if (m_item.delta_bytes !== want.delta_bytes)
                    report_mismatch("delta_bytes", 64'(want.delta_bytes),
                                    64'(m_item.delta_bytes));
                if (m_item.delta_packets !== want.delta_packets)
                    report_mismatch("delta_packets", 64'(want.delta_packets),
                                    64'(m_item.delta_packets));
                if (m_item.total_bytes !== want.total_bytes)
                    report_mismatch("total_bytes", want.total_bytes, m_item.total_bytes);
                if (m_item.total_packets !== want.total_packets)
                    report_mismatch("total_packets", want.total_packets,
                                    m_item.total_packets);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        for (i = 0; i < DIR_ROWS; i++) begin
            push_item(directed_rows[i].stim, directed_rows[i].given, directed_rows[i].want);
        end
        run_phase(32'd0, 200);
        run_phase(32'hFFFF_FFFF, 32'h2000_0000);
        run_phase(32'd1000, 400);
        run_phase(32'($urandom_range(100, 50000)), 30000);
        run_phase(AGE_LIMIT_RESET, 60000000);
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
